[rtl/core/bplcm_pkg.sv]
// shared types and constants for the boosted piecewise-linear curve map
// used by bplcm_div and boosted_piecewise_linear_curve_map_top
package bplcm_pkg;

  localparam int unsigned BREAKPOINT_COUNT_DEF = 8;
  localparam int unsigned SLOT_COUNT           = 8;
  localparam int unsigned SLOT_IDX_W           = 3;
  localparam int unsigned SEG_W                = 4;
  localparam int unsigned DATA_W               = 16;
  localparam int unsigned CFG_IDX_W            = 3;
  localparam int unsigned CFG_DATA_W           = 64;
  localparam int unsigned OUT_TDATA_W          = 24;
  localparam int unsigned DIV_STEPS            = 16;
  localparam int unsigned DIV_CNT_W            = 4;

  localparam logic signed [16:0] CHANGE_LIMIT = 17'sd1229;

  typedef enum logic [2:0] {
    CFG_BP_LO  = 3'd0,
    CFG_BP_HI  = 3'd1,
    CFG_TGT_LO = 3'd2,
    CFG_TGT_HI = 3'd3,
    CFG_GAIN   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOOST,
    ST_SUM,
    ST_SEARCH,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_sts_t;

endpackage

[rtl/core/bplcm_div.sv]
// serial restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle
// quotient is known to fit 16 bits; depends on bplcm_pkg
module bplcm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bplcm_pkg::div_req_t req_i,
  output bplcm_pkg::div_sts_t sts_o
);

  logic [15:0]                     rem_q, rem_d;
  logic [15:0]                     low_q, low_d;
  logic [15:0]                     div_q;
  logic [bplcm_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                            busy_q;
  logic                            done_q;
  logic [16:0]                     shifted;
  logic [17:0]                     trial;
  logic                            ge;

  always_comb begin
    shifted = {rem_q, low_q[15]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    ge      = ~trial[17];
    rem_d   = ge ? trial[15:0] : shifted[15:0];
    low_d   = {low_q[14:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= bplcm_pkg::DIV_CNT_W'(bplcm_pkg::DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[31:16];
      low_q <= req_i.dividend[15:0];
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.quotient = low_q;

endmodule

[rtl/core/boosted_piecewise_linear_curve_map_top.sv]
// Boosted piecewise-linear curve map: one signed Q4.12 sample in, one mapped
// word out. A word that needs the interpolation goes from acceptance to result in these steps:
// - the boost is set up through one shared 18x18 multiplier
// - a search of one breakpoint per cycle
// - the interpolation product on the same multiplier
// - a 16-step bit-serial divide by the segment width, with its start and finish
// - the output register is loaded
// A zero magnitude on a zero-width first segment skips the product and the divide. A magnitude
// beyond all breakpoints also skips them. The input side is ready only while the sequencer is
// idle, which is the cycle after a result is loaded. A finished result waits in the output
// register while the next word is taken. The sequencer holds in its last step while that
// register is still full.
// Depends on bplcm_pkg and bplcm_div.
module boosted_piecewise_linear_curve_map_top #(
  parameter int unsigned BREAKPOINT_COUNT = bplcm_pkg::BREAKPOINT_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bplcm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bplcm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // error_sample [15:0]
  input  logic [bplcm_pkg::DATA_W-1:0]        s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // mapped_curvature [15:0], segment_index [19:16], zero_width_flag [20], zero [23:21]
  output logic [bplcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam logic [bplcm_pkg::SEG_W-1:0] SEG_LAST = bplcm_pkg::SEG_W'(BREAKPOINT_COUNT);

  bplcm_pkg::state_e state_q, state_d;

  logic [15:0]        bp_q  [bplcm_pkg::SLOT_COUNT];
  logic [15:0]        tgt_q [bplcm_pkg::SLOT_COUNT];
  logic signed [15:0] gain_q;
  logic signed [15:0] prev_q;
  logic signed [15:0] sample_q;
  logic signed [11:0] change_q;
  logic signed [35:0] prod_q;
  logic               neg_q;
  logic               zero_q;
  logic [15:0]        mag_q;
  logic [bplcm_pkg::SEG_W-1:0] idx_q;
  logic [15:0]        lo_bp_q;
  logic [15:0]        lo_t_q;
  logic [15:0]        width_q;
  logic signed [16:0] diff_q;
  logic [15:0]        off_q;
  logic signed [16:0] quo_q;
  logic               zw_q;

  logic signed [15:0] out_curv_q;
  logic [bplcm_pkg::SEG_W-1:0] out_seg_q;
  logic               out_zw_q;
  logic               m_valid_q;

  logic               s_accept;
  logic               out_free;
  logic               out_load;
  logic               mul_sel_interp;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  logic signed [16:0] change_raw;
  logic signed [11:0] change_clamp;
  logic signed [17:0] boosted;
  logic [17:0]        boosted_abs;
  logic [15:0]        cur_bp, cur_t;
  logic               at_end;
  logic               step_on;
  logic [35:0]        prod_abs;
  logic signed [17:0] res_raw;
  logic signed [18:0] res_signed;
  logic signed [15:0] res_sat;

  bplcm_pkg::div_req_t div_req;
  bplcm_pkg::div_sts_t div_sts;

  bplcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // datapath helpers
  always_comb begin
    change_raw = {s_axis_tdata_i[15], s_axis_tdata_i} - {prev_q[15], prev_q};
    if (change_raw > bplcm_pkg::CHANGE_LIMIT) begin
      change_clamp = 12'(bplcm_pkg::CHANGE_LIMIT);
    end else if (change_raw < -bplcm_pkg::CHANGE_LIMIT) begin
      change_clamp = 12'(-bplcm_pkg::CHANGE_LIMIT);
    end else begin
      change_clamp = change_raw[11:0];
    end

    mul_a = mul_sel_interp ? {diff_q[16], diff_q} : {{2{gain_q[15]}}, gain_q};
    mul_b = mul_sel_interp ? {2'b00, off_q} : {{6{change_q[11]}}, change_q};
    mul_p = mul_a * mul_b;

    boosted     = {{2{sample_q[15]}}, sample_q} + prod_q[29:12];
    boosted_abs = boosted[17] ? -boosted : boosted;

    cur_bp  = bp_q[idx_q[bplcm_pkg::SLOT_IDX_W-1:0]];
    cur_t   = tgt_q[idx_q[bplcm_pkg::SLOT_IDX_W-1:0]];
    at_end  = (idx_q == SEG_LAST);
    step_on = mag_q > cur_bp;

    prod_abs = prod_q[35] ? 36'(-prod_q) : 36'(prod_q);

    res_raw = $signed({2'b00, lo_t_q}) + {quo_q[16], quo_q};
    if (zero_q) begin
      res_signed = '0;
    end else if (neg_q) begin
      res_signed = -{res_raw[17], res_raw};
    end else begin
      res_signed = {res_raw[17], res_raw};
    end
    if (res_signed > 19'sd32767) begin
      res_sat = 16'sh7fff;
    end else if (res_signed < -19'sd32768) begin
      res_sat = 16'sh8000;
    end else begin
      res_sat = res_signed[15:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bplcm_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = bplcm_pkg::ST_BOOST;
      end
      bplcm_pkg::ST_BOOST: state_d = bplcm_pkg::ST_SUM;
      bplcm_pkg::ST_SUM:   state_d = bplcm_pkg::ST_SEARCH;
      bplcm_pkg::ST_SEARCH: begin
        if (at_end) begin
          state_d = bplcm_pkg::ST_DONE;
        end else if (!step_on) begin
          state_d = (cur_bp == lo_bp_q) ? bplcm_pkg::ST_DONE : bplcm_pkg::ST_MUL;
        end
      end
      bplcm_pkg::ST_MUL:   state_d = bplcm_pkg::ST_START;
      bplcm_pkg::ST_START: state_d = bplcm_pkg::ST_DIV;
      bplcm_pkg::ST_DIV: begin
        if (div_sts.done) state_d = bplcm_pkg::ST_DONE;
      end
      bplcm_pkg::ST_DONE: begin
        if (out_free) state_d = bplcm_pkg::ST_IDLE;
      end
      default: state_d = bplcm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o  = 1'b0;
    mul_sel_interp   = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_abs[31:0];
    div_req.divisor  = width_q;
    case (state_q)
      bplcm_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      bplcm_pkg::ST_MUL:   mul_sel_interp  = 1'b1;
      bplcm_pkg::ST_START: div_req.start   = 1'b1;
      bplcm_pkg::ST_DONE:  out_load        = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bplcm_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      prev_q    <= '0;
      gain_q    <= '0;
      for (int k = 0; k < bplcm_pkg::SLOT_COUNT; k++) begin
        bp_q[k]  <= '0;
        tgt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (s_accept) prev_q <= s_axis_tdata_i;
      if (cfg_we_i) begin
        case (bplcm_pkg::cfg_idx_e'(cfg_index_i))
          bplcm_pkg::CFG_BP_LO: begin
            for (int k = 0; k < 4; k++) bp_q[k] <= cfg_data_i[16*k +: 16];
          end
          bplcm_pkg::CFG_BP_HI: begin
            for (int k = 0; k < 4; k++) bp_q[k+4] <= cfg_data_i[16*k +: 16];
          end
          bplcm_pkg::CFG_TGT_LO: begin
            for (int k = 0; k < 4; k++) tgt_q[k] <= cfg_data_i[16*k +: 16];
          end
          bplcm_pkg::CFG_TGT_HI: begin
            for (int k = 0; k < 4; k++) tgt_q[k+4] <= cfg_data_i[16*k +: 16];
          end
          bplcm_pkg::CFG_GAIN: gain_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bplcm_pkg::ST_IDLE: begin
        if (s_accept) begin
          sample_q <= s_axis_tdata_i;
          change_q <= change_clamp;
        end
      end
      bplcm_pkg::ST_BOOST: prod_q <= mul_p;
      bplcm_pkg::ST_SUM: begin
        neg_q   <= boosted[17];
        zero_q  <= (boosted == '0);
        mag_q   <= boosted_abs[15:0];
        idx_q   <= '0;
        lo_bp_q <= '0;
        lo_t_q  <= '0;
      end
      bplcm_pkg::ST_SEARCH: begin
        if (at_end) begin
          quo_q <= '0;
          zw_q  <= 1'b0;
        end else if (step_on) begin
          lo_bp_q <= cur_bp;
          lo_t_q  <= cur_t;
          idx_q   <= idx_q + 1'b1;
        end else begin
          width_q <= cur_bp - lo_bp_q;
          diff_q  <= $signed({1'b0, cur_t}) - $signed({1'b0, lo_t_q});
          off_q   <= mag_q - lo_bp_q;
          quo_q   <= '0;
          zw_q    <= (cur_bp == lo_bp_q);
        end
      end
      bplcm_pkg::ST_MUL: prod_q <= mul_p;
      bplcm_pkg::ST_DIV: begin
        if (div_sts.done) begin
          quo_q <= prod_q[35] ? -$signed({1'b0, div_sts.quotient})
                              : $signed({1'b0, div_sts.quotient});
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_curv_q <= res_sat;
      out_seg_q  <= idx_q;
      out_zw_q   <= zw_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_zw_q, out_seg_q, out_curv_q};

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == bplcm_pkg::ST_BOOST)
    else $error("accepted word did not start the sequencer");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == bplcm_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> out_seg_q <= SEG_LAST)
    else $error("segment index beyond breakpoint count");

  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_zw_q) |-> (out_curv_q == '0 && out_seg_q == '0))
    else $error("zero-width segment with nonzero result");

endmodule

[bench/boosted_piecewise_linear_curve_map_top_tb.sv]
// self-checking bench for boosted_piecewise_linear_curve_map_top: directed table, then random
// register phases with random stream gaps and stalls, every word checked against a typed word
// of the table or a local map; depends on bplcm_pkg and the block's rtl
module boosted_piecewise_linear_curve_map_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BP_COUNT       = bplcm_pkg::BREAKPOINT_COUNT_DEF;
  localparam int PHASES         = 7;
  localparam int WORDS_PER_PHASE = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam logic [bplcm_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;
  localparam logic [bplcm_pkg::CFG_IDX_W-1:0] CFG_LAST_IDX  = 3'd7;

  typedef struct packed {
    logic [2:0]                    pad;
    logic                          zflag;
    logic [bplcm_pkg::SEG_W-1:0]   seg;
    logic signed [15:0]            curv;
  } map_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic [bplcm_pkg::CFG_IDX_W-1:0]   idx;
    logic [bplcm_pkg::CFG_DATA_W-1:0]  val;
    logic                              typed;
    map_word_t                         want;
  } stim_row_t;

  localparam map_word_t ZERO_FLAGGED = '{pad: 3'd0, zflag: 1'b1, seg: 4'd0, curv: 16'sd0};
  localparam map_word_t BEYOND_ALL   = '{pad: 3'd0, zflag: 1'b0, seg: 4'd8, curv: 16'sd0};
  localparam map_word_t NOT_TYPED    = '0;
  localparam int DIR_ROWS = 34;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0000,                1'b1, ZERO_FLAGGED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h7FFF,                1'b1, BEYOND_ALL},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h8000,                1'b1, BEYOND_ALL},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0000,                1'b1, ZERO_FLAGGED},
    '{ROW_CFG,  bplcm_pkg::CFG_BP_LO,  64'h1000_0C00_0800_0400, 1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_BP_HI,  64'h7000_5000_3000_2000, 1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_TGT_LO, 64'h1400_0C00_0600_0200, 1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_TGT_HI, 64'h8000_FFFF_4000_2000, 1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_GAIN,   64'h2000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0100,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0400,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0500,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0600,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'hFA00,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h7FFF,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h8000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h6000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0001,                1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_GAIN,   64'h8000,                1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_BP_LO,  64'h2000_1000_3000_0000, 1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_TGT_LO, 64'h0000_FFFF_0000_FFFF, 1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h1000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'hF000,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h7FFF,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h8000,                1'b0, NOT_TYPED},
    '{ROW_CFG,  bplcm_pkg::CFG_GAIN,   64'h7FFF,                1'b0, NOT_TYPED},
    '{ROW_CFG,  CFG_SPARE_IDX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NOT_TYPED},
    '{ROW_CFG,  CFG_LAST_IDX,  64'h1234_5678_9ABC_DEF0, 1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0800,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'hF800,                1'b0, NOT_TYPED},
    '{ROW_WORD, bplcm_pkg::CFG_BP_LO,  64'h0000,                1'b0, NOT_TYPED}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [bplcm_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [bplcm_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [bplcm_pkg::DATA_W-1:0]      s_axis_tdata_i = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [bplcm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  // local copy of the block's registers and sample history
  logic [15:0] bp_tab [BP_COUNT];
  logic [15:0] tgt_tab [BP_COUNT];
  longint      gain_q = 0;
  longint      prev_sample = 0;

  map_word_t map_q [$];
  int        mism_cnt = 0;
  int        sent_cnt = 0;
  int        idle_cycles = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;

  boosted_piecewise_linear_curve_map_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int k = 0; k < BP_COUNT; k++) begin
      bp_tab[k] = '0;
      tgt_tab[k] = '0;
    end
  end

  function automatic map_word_t predict_map(input logic [15:0] raw);
    longint    smp, delta, boosted, mag, res, lo_bp, lo_t, hi_bp, hi_t, span;
    int        seg;
    map_word_t w;
    smp = longint'($signed(raw));
    delta = smp - prev_sample;
    if (delta > longint'(bplcm_pkg::CHANGE_LIMIT)) begin
      delta = longint'(bplcm_pkg::CHANGE_LIMIT);
    end else if (delta < -longint'(bplcm_pkg::CHANGE_LIMIT)) begin
      delta = -longint'(bplcm_pkg::CHANGE_LIMIT);
    end
    prev_sample = smp;
    boosted = smp + ((gain_q * delta) >>> 12);
    mag = (boosted < 0) ? -boosted : boosted;
    seg = 0;
    while (seg < BP_COUNT && mag > longint'(bp_tab[seg])) seg++;
    w = '0;
    if (seg >= BP_COUNT) begin
      res = longint'(tgt_tab[BP_COUNT-1]);
    end else begin
      lo_bp = (seg == 0) ? 0 : longint'(bp_tab[seg-1]);
      lo_t  = (seg == 0) ? 0 : longint'(tgt_tab[seg-1]);
      hi_bp = longint'(bp_tab[seg]);
      hi_t  = longint'(tgt_tab[seg]);
      span  = hi_bp - lo_bp;
      if (span <= 0) begin
        w.zflag = 1'b1;
        res = lo_t;
      end else begin
        res = lo_t + ((hi_t - lo_t) * (mag - lo_bp)) / span;
      end
    end
    if (boosted < 0) begin
      res = -res;
    end else if (boosted == 0) begin
      res = 0;
    end
    if (res > 32767) begin
      res = 32767;
    end else if (res < -32768) begin
      res = -32768;
    end
    w.curv = res[15:0];
    w.seg  = seg[bplcm_pkg::SEG_W-1:0];
    return w;
  endfunction

  task automatic write_reg(input logic [bplcm_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [bplcm_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      bplcm_pkg::CFG_BP_LO:  for (int k = 0; k < 4; k++) bp_tab[k] = val[16*k +: 16];
      bplcm_pkg::CFG_BP_HI:  for (int k = 0; k < 4; k++) bp_tab[k+4] = val[16*k +: 16];
      bplcm_pkg::CFG_TGT_LO: for (int k = 0; k < 4; k++) tgt_tab[k] = val[16*k +: 16];
      bplcm_pkg::CFG_TGT_HI: for (int k = 0; k < 4; k++) tgt_tab[k+4] = val[16*k +: 16];
      bplcm_pkg::CFG_GAIN:   gain_q = longint'($signed(val[15:0]));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (map_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [15:0] smp, input logic typed, input map_word_t want);
    int        gap;
    map_word_t w;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    do @(posedge clk_i); while (!s_axis_tready_o);
    w = predict_map(smp);
    map_q.push_back(typed ? want : w);
    sent_cnt++;
    if (sent_cnt % 64 == 0) begin
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
    end
  endtask

  task automatic run_phase(input int p);
    logic [15:0] bps [BP_COUNT];
    logic [15:0] tgts [BP_COUNT];
    logic [15:0] gain, smp;
    longint      near;
    int          acc, step, mode;
    step = (p % 3 == 0) ? 1024 : (p % 3 == 1) ? 4096 : 9000;
    acc = 0;
    for (int k = 0; k < BP_COUNT; k++) begin
      acc += $urandom_range(0, step);
      case (p)
        3:       bps[k] = 16'hFFFF;
        4:       bps[k] = 16'($urandom);
        5:       bps[k] = 16'h0000;
        default: bps[k] = (acc > 65535) ? 16'hFFFF : 16'(acc);
      endcase
      case (p)
        1, 3:    tgts[k] = 16'hFFFF;
        2:       tgts[k] = 16'h0000;
        default: tgts[k] = 16'($urandom);
      endcase
    end
    if (p == 6) bps[0] = 16'h0000;
    case (p)
      0:       gain = 16'h8000;
      1:       gain = 16'h7FFF;
      2:       gain = 16'h0000;
      default: gain = 16'($urandom);
    endcase
    wait_idle();
    write_reg(bplcm_pkg::CFG_BP_LO,  {bps[3], bps[2], bps[1], bps[0]});
    write_reg(bplcm_pkg::CFG_BP_HI,  {bps[7], bps[6], bps[5], bps[4]});
    write_reg(bplcm_pkg::CFG_TGT_LO, {tgts[3], tgts[2], tgts[1], tgts[0]});
    write_reg(bplcm_pkg::CFG_TGT_HI, {tgts[7], tgts[6], tgts[5], tgts[4]});
    write_reg(bplcm_pkg::CFG_GAIN,   {48'h0, gain});
    write_reg(3'($urandom_range(CFG_SPARE_IDX, CFG_LAST_IDX)), {$urandom, $urandom});
    for (int n = 0; n < WORDS_PER_PHASE; n++) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2: smp = 16'($urandom);
        3, 4, 5: smp = prev_sample[15:0] + 16'($urandom_range(0, 4000)) - 16'd2000;
        6, 7: begin
          near = longint'(bp_tab[$urandom_range(0, BP_COUNT-1)]) + $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 1) != 0) near = -near;
          smp = near[15:0];
        end
        8:       smp = 16'h0000;
        default: smp = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      endcase
      send_word(smp, 1'b0, NOT_TYPED);
    end
  endtask

  // result side: random stalls, compare against the oldest expected word
  initial begin
    int        stall;
    map_word_t got, want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = m_axis_tdata_o;
      if (map_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS) $display("unexpected word %h", got);
      end else begin
        want = map_q.pop_front();
        if (got.curv !== want.curv || got.seg !== want.seg || got.zflag !== want.zflag ||
            got.pad !== want.pad) begin
          mism_cnt++;
          if (mism_cnt <= MAX_REPORTS)
            $display(
              "mismatch: exp curv %0d seg %0d flag %0d, got curv %0d seg %0d flag %0d pad %0d",
              want.curv, want.seg, want.zflag, got.curv, got.seg, got.zflag, got.pad);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("boosted_piecewise_linear_curve_map_top_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        send_word(dir_tab[r].val[15:0], dir_tab[r].typed, dir_tab[r].want);
      end
    end
    for (int p = 0; p < PHASES; p++) run_phase(p);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mism_cnt == 0 && map_q.size() == 0) begin
      $display("boosted_piecewise_linear_curve_map_top_tb OK");
    end else begin
      $display("boosted_piecewise_linear_curve_map_top_tb NOT OK");
    end
    $finish;
  end

endmodule
